### rtl/edfs_pkg.sv
`timescale 1ns / 1ps

package edfs_pkg;

    localparam int TASK_SLOTS_DEF = 8;
    localparam int TIME_BITS_DEF  = 32;

    localparam int CMD_W    = 2;
    localparam int INDEX_W  = 3;
    localparam int VAL16_W  = 16;
    localparam int COUNT_W  = 4;
    localparam int MASK_W   = 8;
    localparam int TICK_W   = 32;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STATS = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

    // saturating counter step
    function automatic logic [VAL16_W-1:0] sat_inc(input logic [VAL16_W-1:0] v);
        sat_inc = (v == '1) ? v : v + VAL16_W'(1);
    endfunction

endpackage

### rtl/edf_periodic_task_scheduler.sv
`timescale 1ns / 1ps
// Channel   Handshake            Word
// s_        s_valid / s_ready    command, task_index, task_period, task_burst
// m_        m_valid / m_ready    result_kind, tick report fields, statistics
// cfg_      cfg_valid/cfg_ready  task_count (always ready)
//
// A tick scans n = active task entries (clamped to TASK_SLOTS), then writes its result:
// one shared release/compare unit walks the task memory one entry per cycle.
// Load, stats and unknown commands go straight to the result state. s_ready is high only while idle.
// The result register frees the input side; a finished word waits there for m_ready.
// aresetn is synchronous; the task memory reads as zero until an entry is written.

module edf_periodic_task_scheduler #(
    parameter int TASK_SLOTS = edfs_pkg::TASK_SLOTS_DEF,
    parameter int TIME_BITS  = edfs_pkg::TIME_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [edfs_pkg::COUNT_W-1:0] cfg_task_count,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [edfs_pkg::CMD_W-1:0]   s_command,
    input  logic [edfs_pkg::INDEX_W-1:0] s_task_index,
    input  logic [edfs_pkg::VAL16_W-1:0] s_task_period,
    input  logic [edfs_pkg::VAL16_W-1:0] s_task_burst,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [edfs_pkg::CMD_W-1:0]   m_result_kind,
    output logic                         m_cpu_busy,
    output logic [edfs_pkg::INDEX_W-1:0] m_running_task,
    output logic                         m_job_completed,
    output logic [edfs_pkg::MASK_W-1:0]  m_missed_mask,
    output logic [edfs_pkg::TICK_W-1:0]  m_tick_time,
    output logic [edfs_pkg::VAL16_W-1:0] m_completed_jobs,
    output logic [edfs_pkg::VAL16_W-1:0] m_missed_jobs
);
    import edfs_pkg::*;

    localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CNT_W = $clog2(TASK_SLOTS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    typedef struct packed {
        logic [VAL16_W-1:0]   period;
        logic [VAL16_W-1:0]   burst;
        logic [TIME_BITS-1:0] rel_time;
        logic [TIME_BITS-1:0] deadline;
        logic [VAL16_W-1:0]   remaining;
        logic [VAL16_W-1:0]   done_cnt;
        logic [VAL16_W-1:0]   miss_cnt;
    } entry_t;

    // task memory, one write and one registered read per cycle
    entry_t                mem [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] vld_reg, vld_next;
    entry_t                rd_data_reg;
    logic                  rd_vld_reg;

    logic [1:0]           state_reg, state_next;
    logic [COUNT_W-1:0]   task_count_reg;
    logic [TIME_BITS-1:0] time_now_reg, time_now_next;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic                 idx_ok_reg, idx_ok_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    entry_t               best_reg, best_next;
    logic [MASK_W-1:0]    mask_reg, mask_next;

    logic                 m_valid_reg, m_valid_next;
    logic [CMD_W-1:0]     m_kind_reg, m_kind_next;
    logic                 m_busy_reg, m_busy_next;
    logic [INDEX_W-1:0]   m_run_reg, m_run_next;
    logic                 m_done_reg, m_done_next;
    logic [MASK_W-1:0]    m_mask_reg, m_mask_next;
    logic [TICK_W-1:0]    m_time_reg, m_time_next;
    logic [VAL16_W-1:0]   m_cjobs_reg, m_cjobs_next;
    logic [VAL16_W-1:0]   m_mjobs_reg, m_mjobs_next;

    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    entry_t               wr_data;

    logic                 s_fire;
    logic                 s_idx_ok;
    logic [IDX_W-1:0]     s_addr;
    logic [CNT_W-1:0]     n_cnt;
    logic                 scan_last;
    logic                 out_free;
    entry_t               ent, upd, fin;
    logic                 rel_hit;
    logic                 better;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign s_idx_ok  = (32'(s_task_index) < 32'(TASK_SLOTS));
    assign s_addr    = IDX_W'(s_task_index);
    assign n_cnt     = (32'(task_count_reg) > 32'(TASK_SLOTS)) ? CNT_W'(TASK_SLOTS)
                                                               : CNT_W'(task_count_reg);
    assign scan_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == n_cnt);
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        // release and compare unit, fed by the entry in the read register
        ent     = rd_vld_reg ? rd_data_reg : '0;
        rel_hit = (ent.rel_time == time_now_reg);
        upd     = ent;
        if (rel_hit) begin
            if (ent.remaining != '0) begin
                upd.miss_cnt = sat_inc(ent.miss_cnt);
            end
            upd.remaining = ent.burst;
            upd.rel_time  = ent.rel_time + TIME_BITS'(ent.period);
            upd.deadline  = time_now_reg + TIME_BITS'(ent.period);
        end
        better = (upd.remaining != '0) &&
                 (!found_reg || (upd.deadline < best_reg.deadline) ||
                  ((upd.deadline == best_reg.deadline) && (upd.period < best_reg.period)));

        fin = best_reg;
        fin.remaining = best_reg.remaining - VAL16_W'(1);
        if (best_reg.remaining == VAL16_W'(1)) begin
            fin.done_cnt = sat_inc(best_reg.done_cnt);
        end
    end

    always_comb begin
        state_next    = state_reg;
        time_now_next = time_now_reg;
        cmd_next      = cmd_reg;
        idx_ok_next   = idx_ok_reg;
        idx_next      = idx_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        mask_next     = mask_reg;
        vld_next      = vld_reg;

        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = upd;

        m_valid_next = m_valid_reg && !m_ready;
        m_kind_next  = m_kind_reg;
        m_busy_next  = m_busy_reg;
        m_run_next   = m_run_reg;
        m_done_next  = m_done_reg;
        m_mask_next  = m_mask_reg;
        m_time_next  = m_time_reg;
        m_cjobs_next = m_cjobs_reg;
        m_mjobs_next = m_mjobs_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    cmd_next    = s_command;
                    idx_ok_next = s_idx_ok;
                    idx_next    = '0;
                    found_next  = 1'b0;
                    mask_next   = '0;
                    state_next  = ST_OUT;
                    unique case (s_command)
                        CMD_TICK: begin
                            rd_en   = 1'b1;
                            rd_addr = '0;
                            if (n_cnt != '0) begin
                                state_next = ST_SCAN;
                            end
                        end
                        CMD_LOAD: begin
                            if (s_idx_ok) begin
                                wr_en   = 1'b1;
                                wr_addr = s_addr;
                                wr_data = '{period:    s_task_period,
                                            burst:     s_task_burst,
                                            rel_time:  time_now_reg,
                                            deadline:  time_now_reg + TIME_BITS'(s_task_period),
                                            remaining: '0,
                                            done_cnt:  '0,
                                            miss_cnt:  '0};
                            end
                        end
                        CMD_STATS: begin
                            rd_en   = 1'b1;
                            rd_addr = s_addr;
                        end
                        default: ;
                    endcase
                end
            end

            ST_SCAN: begin
                if (rel_hit) begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg;
                    wr_data = upd;
                    if ((ent.remaining != '0) && (32'(idx_reg) < MASK_W)) begin
                        mask_next[3'(idx_reg)] = 1'b1;
                    end
                end
                if (better) begin
                    found_next    = 1'b1;
                    best_idx_next = idx_reg;
                    best_next     = upd;
                end
                if (scan_last) begin
                    state_next = ST_OUT;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + IDX_W'(1);
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = cmd_reg;
                    m_busy_next  = 1'b0;
                    m_run_next   = '0;
                    m_done_next  = 1'b0;
                    m_mask_next  = '0;
                    m_time_next  = '0;
                    m_cjobs_next = '0;
                    m_mjobs_next = '0;
                    unique case (cmd_reg)
                        CMD_TICK: begin
                            if (found_reg) begin
                                wr_en       = 1'b1;
                                wr_addr     = best_idx_reg;
                                wr_data     = fin;
                                m_busy_next = 1'b1;
                                m_run_next  = 3'(best_idx_reg);
                                m_done_next = (best_reg.remaining == VAL16_W'(1));
                            end
                            m_mask_next   = mask_reg;
                            m_time_next   = TICK_W'(time_now_reg);
                            time_now_next = time_now_reg + TIME_BITS'(1);
                        end
                        CMD_STATS: begin
                            if (idx_ok_reg && rd_vld_reg) begin
                                m_cjobs_next = rd_data_reg.done_cnt;
                                m_mjobs_next = rd_data_reg.miss_cnt;
                            end
                        end
                        default: ;
                    endcase
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase

        if (wr_en) begin
            vld_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
            rd_vld_reg  <= vld_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            task_count_reg <= '0;
            time_now_reg   <= '0;
            vld_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            time_now_reg <= time_now_next;
            vld_reg      <= vld_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                task_count_reg <= cfg_task_count;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        idx_ok_reg   <= idx_ok_next;
        idx_reg      <= idx_next;
        found_reg    <= found_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        mask_reg     <= mask_next;
        m_kind_reg   <= m_kind_next;
        m_busy_reg   <= m_busy_next;
        m_run_reg    <= m_run_next;
        m_done_reg   <= m_done_next;
        m_mask_reg   <= m_mask_next;
        m_time_reg   <= m_time_next;
        m_cjobs_reg  <= m_cjobs_next;
        m_mjobs_reg  <= m_mjobs_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_result_kind    = m_kind_reg;
    assign m_cpu_busy       = m_busy_reg;
    assign m_running_task   = m_run_reg;
    assign m_job_completed  = m_done_reg;
    assign m_missed_mask    = m_mask_reg;
    assign m_tick_time      = m_time_reg;
    assign m_completed_jobs = m_cjobs_reg;
    assign m_missed_jobs    = m_mjobs_reg;

endmodule
